[rtl/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg
// Shared widths, defaults and the float ordering key for the top-k selector.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int unsigned MAX_KEEP_DEF       = 16;
  localparam int unsigned POSITION_WIDTH_DEF = 20;
  localparam int unsigned SCORE_W            = 32;
  localparam int unsigned KEEP_W             = 5;
  localparam int unsigned RANK_W             = 4;
  localparam int unsigned POS_OUT_W          = 20;
  localparam logic [KEEP_W-1:0] KEEP_RESET   = 5'd5;
  localparam logic [7:0]  EXP_ALL_ONES       = 8'hFF;

  // Map float bits to an unsigned key whose order follows the real order
  function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] b);
    logic [SCORE_W-1:0] key;
    if (b[SCORE_W-2:0] == '0) begin
      key = {1'b1, {(SCORE_W-1){1'b0}}};
    end else if (b[SCORE_W-1]) begin
      key = ~b;
    end else begin
      key = {1'b1, b[SCORE_W-2:0]};
    end
    return key;
  endfunction

endpackage

[rtl/stk_list.sv]
// ----------------------------------------------------------------------------
// stk_list
// Sorted insertion list: one score compared against every held entry in
// parallel and shifted into place when it is taken.
// ----------------------------------------------------------------------------
module stk_list #(
  parameter int unsigned MAX_KEEP       = stk_pkg::MAX_KEEP_DEF,
  parameter int unsigned POSITION_WIDTH = stk_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned KW             = $clog2(MAX_KEEP + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          clr,
  input  logic [KW-1:0]                 k_eff,
  input  logic [stk_pkg::SCORE_W-1:0]   score,
  input  logic [POSITION_WIDTH-1:0]     pos,
  output logic [stk_pkg::SCORE_W-1:0]   nxt_score [MAX_KEEP],
  output logic [POSITION_WIDTH-1:0]     nxt_pos   [MAX_KEEP],
  output logic [KW-1:0]                 nxt_fill
);
  import stk_pkg::*;

  logic [SCORE_W-1:0]        score_r [MAX_KEEP];
  logic [POSITION_WIDTH-1:0] pos_r   [MAX_KEEP];
  logic [KW-1:0]             fill_r;
  logic [KW-1:0]             fill_eff;
  logic [KW-1:0]             at;
  logic [SCORE_W-1:0]        key_new;
  logic                      finite;
  logic                      do_ins;

  // Truncate to k and count held entries that rank at or above the new score
  always_comb begin
    fill_eff = (fill_r > k_eff) ? k_eff : fill_r;
    key_new  = order_key(score);
    finite   = (score[30:23] != EXP_ALL_ONES);
    at       = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if ((KW'(i) < fill_eff) && (order_key(score_r[i]) >= key_new)) begin
        at = at + KW'(1);
      end
    end
    do_ins = finite && ((fill_eff < k_eff) || (at < k_eff));
  end

  // Build the shifted list
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      nxt_score[i] = score_r[i];
      nxt_pos[i]   = pos_r[i];
      if (do_ins) begin
        if (KW'(i) == at) begin
          nxt_score[i] = score;
          nxt_pos[i]   = pos;
        end else if ((KW'(i) > at) && (i > 0)) begin
          nxt_score[i] = score_r[(i > 0) ? i - 1 : 0];
          nxt_pos[i]   = pos_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
    if (do_ins) begin
      nxt_fill = (fill_eff < k_eff) ? fill_eff + KW'(1) : k_eff;
    end else begin
      nxt_fill = fill_eff;
    end
  end

  // Hold the fill level; clear it at the end of a vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (upd) begin
      fill_r <= clr ? '0 : nxt_fill;
    end
  end

  // Advance the entries
  always_ff @(posedge clk) begin
    if (upd) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        score_r[i] <= nxt_score[i];
        pos_r[i]   <= nxt_pos[i];
      end
    end
  end

endmodule

[rtl/streaming_topk_selector.sv]
// ----------------------------------------------------------------------------
// streaming_topk_selector
// Keeps the k highest float scores of a vector and reports them in rank order.
// ----------------------------------------------------------------------------
// One score is taken every cycle: each request is compared against all held
// entries in parallel and inserted in the same cycle. A request with tlast
// copies the finished list into a result buffer. The buffer drains one result
// per cycle while out_tready is high: one per held entry, up to k, or a single
// result for an empty vector. The next vector streams in meanwhile; only a
// following tlast request waits, and it is taken in the cycle the last result
// leaves.
module streaming_topk_selector #(
  parameter int unsigned MAX_KEEP       = stk_pkg::MAX_KEEP_DEF,
  parameter int unsigned POSITION_WIDTH = stk_pkg::POSITION_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [31:0] score_bits
  input  logic                         in_tlast,   // final_item
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [55:0]                  out_tdata,  // [3:0] rank, [23:4] position, [55:24] score_out
  output logic                         out_tuser,  // none_kept
  output logic                         out_tlast,  // last_of_run
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stk_pkg::KEEP_W-1:0]   cfg_data
);
  import stk_pkg::*;

  localparam int unsigned KW = $clog2(MAX_KEEP + 1);

  logic [KEEP_W-1:0]         keep_count_r;
  logic [KW-1:0]             k_eff;
  logic [POSITION_WIDTH-1:0] item_cnt_r;
  logic                      in_acc;
  logic                      pop;
  logic                      load;

  logic [SCORE_W-1:0]        nxt_score [MAX_KEEP];
  logic [POSITION_WIDTH-1:0] nxt_pos   [MAX_KEEP];
  logic [KW-1:0]             nxt_fill;

  logic [SCORE_W-1:0]        snap_score_r [MAX_KEEP];
  logic [POSITION_WIDTH-1:0] snap_pos_r   [MAX_KEEP];
  logic [KW-1:0]             remain_r;
  logic [RANK_W-1:0]         rank_r;
  logic                      empty_r;
  logic                      busy_r;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
    end else if (cfg_valid) begin
      keep_count_r <= cfg_data;
    end
  end

  // Clamp k into 1..MAX_KEEP
  always_comb begin
    if (keep_count_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(keep_count_r) > MAX_KEEP) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = KW'(keep_count_r);
    end
  end

  // Handshakes: a final request waits for the buffer to drain
  assign pop       = busy_r && out_tready;
  assign in_tready = !busy_r || !in_tlast || (out_tready && remain_r == KW'(1));
  assign in_acc    = in_tvalid && in_tready;
  assign load      = in_acc && in_tlast;

  // Item counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
    end else if (in_acc) begin
      item_cnt_r <= in_tlast ? '0 : item_cnt_r + POSITION_WIDTH'(1);
    end
  end

  stk_list #(
    .MAX_KEEP       (MAX_KEEP),
    .POSITION_WIDTH (POSITION_WIDTH),
    .KW             (KW)
  ) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (in_acc),
    .clr       (in_tlast),
    .k_eff     (k_eff),
    .score     (in_tdata),
    .pos       (item_cnt_r),
    .nxt_score (nxt_score),
    .nxt_pos   (nxt_pos),
    .nxt_fill  (nxt_fill)
  );

  // Result buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      remain_r <= '0;
      rank_r   <= '0;
      empty_r  <= 1'b0;
    end else if (load) begin
      busy_r   <= 1'b1;
      remain_r <= (nxt_fill == '0) ? KW'(1) : nxt_fill;
      rank_r   <= '0;
      empty_r  <= (nxt_fill == '0);
    end else if (pop) begin
      busy_r   <= (remain_r != KW'(1));
      remain_r <= remain_r - KW'(1);
      rank_r   <= rank_r + RANK_W'(1);
    end
  end

  // Result buffer payload: load a snapshot, shift toward slot 0 on each pop
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        snap_score_r[i] <= nxt_score[i];
        snap_pos_r[i]   <= nxt_pos[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_KEEP - 1; i++) begin
        snap_score_r[i] <= snap_score_r[i+1];
        snap_pos_r[i]   <= snap_pos_r[i+1];
      end
    end
  end

  // Drive the result channel
  assign out_tvalid = busy_r;
  assign out_tlast  = (remain_r == KW'(1));
  assign out_tuser  = empty_r;
  assign out_tdata  = empty_r ? '0 :
                      {snap_score_r[0], POS_OUT_W'(snap_pos_r[0]), rank_r};

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming top-k float score selector.
// ----------------------------------------------------------------------------
// Score vectors are streamed in. A behavioral sorted list predicts the ranked
// results of every vector, and each result request is compared field by field
// against the oldest prediction. Both handshakes idle at random. keep_count is
// rewritten between phases and once mid-vector, each time once the block has gone idle.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stk_pkg::*;

  typedef struct packed {
    logic        last_of_run;
    logic        none_kept;
    logic [31:0] score_out;
    logic [19:0] position;
    logic [3:0]  rank;
  } topk_result_t;

  // Sorted-list predictor and queue of pending ranked results
  class topk_scoreboard;
    logic [31:0]  held_score[16];
    logic [19:0]  held_pos[16];
    int unsigned  held_cnt;
    logic [19:0]  item_idx;
    logic [4:0]   keep_reg;
    topk_result_t pending[$];
    int           errors;

    function new();
      held_cnt = 0;
      item_idx = '0;
      keep_reg = KEEP_RESET;
      errors   = 0;
    endfunction

    function logic [31:0] rank_key(logic [31:0] b);
      if (b[30:0] == '0) return 32'h8000_0000;
      if (b[31]) return ~b;
      return b | 32'h8000_0000;
    endfunction

    function void note_score(logic [31:0] bits, logic fin);
      int unsigned  k, n, at;
      topk_result_t r;
      k = (keep_reg == 0) ? 1 : (keep_reg > 16 ? 16 : keep_reg);
      if (held_cnt > k) held_cnt = k;
      if (bits[30:23] != EXP_ALL_ONES) begin
        n = held_cnt;
        if (held_cnt >= k) begin
          if (rank_key(bits) > rank_key(held_score[k-1])) n = k - 1;
          else n = 99;
        end
        if (n != 99) begin
          at = 0;
          while (at < n && rank_key(held_score[at]) >= rank_key(bits)) at++;
          for (int i = n; i > at; i--) begin
            held_score[i] = held_score[i-1];
            held_pos[i]   = held_pos[i-1];
          end
          held_score[at] = bits;
          held_pos[at]   = item_idx;
          held_cnt       = n + 1;
        end
      end
      item_idx++;
      if (!fin) return;
      if (held_cnt == 0) begin
        r = '0;
        r.none_kept = 1'b1;
        r.last_of_run = 1'b1;
        pending.insert(pending.size(), r);
      end else begin
        for (int i = 0; i < held_cnt; i++) begin
          r.rank        = i[3:0];
          r.position    = held_pos[i];
          r.score_out   = held_score[i];
          r.none_kept   = 1'b0;
          r.last_of_run = (i + 1 == held_cnt);
          pending.insert(pending.size(), r);
        end
      end
      held_cnt = 0;
      item_idx = '0;
    endfunction

    function void check_result(topk_result_t got);
      topk_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result request %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.rank != exp.rank) begin
        $error("rank: expected %0d actual %0d", exp.rank, got.rank); errors++;
      end
      if (got.position != exp.position) begin
        $error("position: expected %0d actual %0d", exp.position, got.position); errors++;
      end
      if (got.score_out != exp.score_out) begin
        $error("score_out: expected %h actual %h", exp.score_out, got.score_out); errors++;
      end
      if (got.none_kept != exp.none_kept) begin
        $error("none_kept: expected %0b actual %0b", exp.none_kept, got.none_kept); errors++;
      end
      if (got.last_of_run != exp.last_of_run) begin
        $error("last_of_run: expected %0b actual %0b", exp.last_of_run,
               got.last_of_run); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  topk_scoreboard board = new();
  bit          calm_phase = 1'b0;
  int unsigned cycle_cnt = 0;
  localparam int unsigned CYCLE_LIMIT = 200000;

  streaming_topk_selector dut (.*);

  always #5 clk = ~clk;

  // Randomly stall the result side; never stall during the calm stretch
  always @(posedge clk) begin
    topk_result_t got;
    if (out_tvalid && out_tready) begin
      got.rank        = out_tdata[3:0];
      got.position    = out_tdata[23:4];
      got.score_out   = out_tdata[55:24];
      got.none_kept   = out_tuser;
      got.last_of_run = out_tlast;
      board.check_result(got);
    end
    out_tready <= rst_n && (calm_phase || $urandom_range(99) >= 21);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold tvalid high across back-to-back requests; drop it only while idling
  task automatic send_score(logic [31:0] bits, logic fin);
    while (!calm_phase && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_score(bits, fin);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_keep(logic [4:0] k);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.keep_reg = k;
    cfg_valid <= 1'b0;
  endtask

  // Mostly finite scores of both signs, with zeros, ties and non-finite noise
  function automatic logic [31:0] pick_score();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return {1'($urandom_range(1)), 31'd0};
    if (sel < 16) return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
    if (sel < 30) return {1'($urandom_range(1)), 8'd127, 23'($urandom_range(3))};
    return {1'($urandom_range(1)), 8'($urandom_range(254)), 23'($urandom)};
  endfunction

  task automatic send_vector(int unsigned len);
    for (int i = 0; i < len; i++) send_score(pick_score(), i == len - 1);
  endtask

  initial begin
    logic [4:0] keep_plan[6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd5};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, signed zeros, ties, non-finite, empty vector
    send_score(32'h7F7F_FFFF, 1'b0);
    send_score(32'hFF7F_FFFF, 1'b0);
    send_score(32'h0000_0000, 1'b0);
    send_score(32'h8000_0000, 1'b0);
    send_score(32'h7F80_0000, 1'b0);
    send_score(32'hFFC0_0001, 1'b0);
    send_score(32'h0000_0001, 1'b0);
    send_score(32'h8000_0001, 1'b0);
    send_score(32'h3F80_0000, 1'b0);
    send_score(32'h3F80_0000, 1'b1);
    send_score(32'hFFFF_FFFF, 1'b1);
    send_score(32'h4000_0000, 1'b1);
    send_score(32'hAAAA_AAAA, 1'b0);
    send_score(32'h5555_5555, 1'b1);
    drain_results();

    // Lower k mid-vector: list truncates on the next score
    write_keep(5'd16);
    for (int i = 0; i < 10; i++) send_score(32'h3F80_0000 + i, 1'b0);
    drain_results();
    board.keep_reg = 5'd2;
    cfg_valid <= 1'b1;
    cfg_data  <= 5'd2;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    send_score(32'h3F00_0000, 1'b1);

    // Random phases across keep settings; first one runs without idling
    foreach (keep_plan[p]) begin
      write_keep(keep_plan[p]);
      calm_phase = (p == 0);
      for (int v = 0; v < 7; v++) send_vector($urandom_range(1, 6));
      calm_phase = 1'b0;
    end
    drain_results();

    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[streaming_topk_selector.f]
rtl/stk_pkg.sv
rtl/stk_list.sv
rtl/streaming_topk_selector.sv
tb/sv/tb.sv
